>>> rtl/ajrb_pkg.sv
package ajrb_pkg;

    localparam int RING_DEPTH = 16384;
    localparam int MAX_BURST  = 64;
    localparam int FRAME_MAX  = 4096;

    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int LVL_W   = 14;
    localparam int CMP_W   = (IDX_W > LVL_W) ? IDX_W : LVL_W;
    localparam int FLEN_W  = 13;
    localparam int FPOS_W  = 12;
    localparam int SMP_W   = 16;
    localparam int BURST_W = 7;
    localparam int CNT_W   = $clog2(MAX_BURST + 1);
    localparam int CFG_W   = 14;
    localparam int CIDX_W  = 2;

    localparam logic [FLEN_W-1:0] FRAME_LEN_RST  = FLEN_W'(960);
    localparam logic [LVL_W-1:0]  START_LVL_RST  = LVL_W'(3840);
    localparam logic [LVL_W-1:0]  HIGH_LVL_RST   = LVL_W'(9600);
    localparam logic [LVL_W-1:0]  TARGET_LVL_RST = LVL_W'(4800);

    localparam logic [CIDX_W-1:0] REG_FRAME_LEN  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_START_LVL  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_HIGH_LVL   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_TARGET_LVL = 2'd3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef struct packed {
        logic push;
        logic pull_start;
        logic issue;
    } t_cmd;

    typedef struct packed {
        logic last_left;
    } t_status;

endpackage

>>> rtl/ajrb_ram.sv
module ajrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ajrb_ctrl.sv
module ajrb_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [ajrb_pkg::BURST_W-1:0]      i_burst_len,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ajrb_pkg::t_cmd                    o_cmd,
    input  ajrb_pkg::t_status                 i_status
);
    import ajrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd.push       = 1'b0;
        o_cmd.pull_start = 1'b0;
        o_cmd.issue      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else if (i_burst_len != '0) begin
                        o_cmd.pull_start = 1'b1;
                        n_state          = ST_BURST;
                    end
                end
            end
            ST_BURST: begin
                if (out_free) begin
                    o_cmd.issue = 1'b1;
                    if (i_status.last_left) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.issue) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/ajrb_dp.sv
module ajrb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ajrb_pkg::t_cmd                    i_cmd,
    output ajrb_pkg::t_status                 o_status,
    input  logic [ajrb_pkg::SMP_W-1:0]        i_sample,
    input  logic [ajrb_pkg::BURST_W-1:0]      i_burst_len,
    input  logic                              i_cfg_we,
    input  logic [ajrb_pkg::CIDX_W-1:0]       i_cfg_idx,
    input  logic [ajrb_pkg::CFG_W-1:0]        i_cfg_data,
    output logic [ajrb_pkg::SMP_W-1:0]        o_sample,
    output logic                              o_silent,
    output logic                              o_last
);
    import ajrb_pkg::*;

    logic [FLEN_W-1:0] r_frame_len;
    logic [LVL_W-1:0]  r_start_lvl;
    logic [LVL_W-1:0]  r_high_lvl;
    logic [LVL_W-1:0]  r_target_lvl;

    logic [IDX_W-1:0]  r_cwi, n_cwi;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_playing, n_playing;
    logic [FPOS_W-1:0] r_fpos, n_fpos;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic              r_silent, n_silent;
    logic              r_last, n_last;

    logic [IDX_W-1:0]  level;
    logic [FLEN_W-1:0] frame_len;
    logic [FLEN_W-1:0] fpos_inc;
    logic [IDX_W-1:0]  waddr;
    logic [BURST_W-1:0] burst_sat;
    logic              pull_silent;
    logic [SMP_W-1:0]  ram_q;

    assign level    = r_cwi - r_rd_idx;
    assign fpos_inc = FLEN_W'(r_fpos) + FLEN_W'(1);
    assign waddr    = r_cwi + IDX_W'(r_fpos);

    always_comb begin
        if (r_frame_len == '0) begin
            frame_len = FLEN_W'(1);
        end else if (r_frame_len > FLEN_W'(FRAME_MAX)) begin
            frame_len = FLEN_W'(FRAME_MAX);
        end else begin
            frame_len = r_frame_len;
        end
        if (i_burst_len > BURST_W'(MAX_BURST)) begin
            burst_sat = BURST_W'(MAX_BURST);
        end else begin
            burst_sat = i_burst_len;
        end
        pull_silent = !r_playing || (CMP_W'(level) < CMP_W'(burst_sat));
    end

    always_comb begin
        n_cwi     = r_cwi;
        n_rd_idx  = r_rd_idx;
        n_playing = r_playing;
        n_fpos    = r_fpos;
        n_left    = r_left;
        n_addr    = r_addr;
        n_silent  = r_silent;
        n_last    = r_last;
        if (i_cmd.push) begin
            if (r_fpos == '0) begin
                if (CMP_W'(level) > CMP_W'(r_high_lvl)) begin
                    n_rd_idx = r_cwi - IDX_W'(r_target_lvl);
                end
                if (CMP_W'(level) >= CMP_W'(r_start_lvl)) begin
                    n_playing = 1'b1;
                end
            end
            if (fpos_inc >= frame_len) begin
                n_cwi  = r_cwi + IDX_W'(fpos_inc);
                n_fpos = '0;
            end else begin
                n_fpos = FPOS_W'(fpos_inc);
            end
        end
        if (i_cmd.pull_start) begin
            n_left   = CNT_W'(burst_sat);
            n_addr   = r_rd_idx;
            n_silent = pull_silent;
            if (pull_silent) begin
                n_playing = 1'b0;
            end else begin
                n_rd_idx = r_rd_idx + IDX_W'(burst_sat);
            end
        end
        if (i_cmd.issue) begin
            n_left = r_left - CNT_W'(1);
            n_addr = r_addr + IDX_W'(1);
            n_last = (r_left == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len  <= FRAME_LEN_RST;
            r_start_lvl  <= START_LVL_RST;
            r_high_lvl   <= HIGH_LVL_RST;
            r_target_lvl <= TARGET_LVL_RST;
            r_cwi        <= '0;
            r_rd_idx     <= '0;
            r_playing    <= 1'b0;
            r_fpos       <= '0;
            r_left       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FRAME_LEN:  r_frame_len  <= i_cfg_data[FLEN_W-1:0];
                    REG_START_LVL:  r_start_lvl  <= i_cfg_data[LVL_W-1:0];
                    REG_HIGH_LVL:   r_high_lvl   <= i_cfg_data[LVL_W-1:0];
                    REG_TARGET_LVL: r_target_lvl <= i_cfg_data[LVL_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_cwi     <= n_cwi;
            r_rd_idx  <= n_rd_idx;
            r_playing <= n_playing;
            r_fpos    <= n_fpos;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_silent <= n_silent;
        r_last   <= n_last;
    end

    ajrb_ram #(
        .WIDTH(SMP_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push),
        .i_waddr(waddr),
        .i_wdata(i_sample),
        .i_re   (i_cmd.issue),
        .i_raddr(r_addr),
        .o_rdata(ram_q)
    );

    assign o_status.last_left = (r_left == CNT_W'(1));
    assign o_sample = r_silent ? '0 : ram_q;
    assign o_silent = r_silent;
    assign o_last   = r_last;

endmodule

>>> rtl/audio_jitter_ring_buffer.sv
// A push request gives no result; pushes can follow every cycle while no pull burst runs and
// the output is not stalled. A pull request of N samples (N capped at 64, none for N = 0)
// returns N results at one per cycle while the output is not stalled; the first result follows
// the burst state register and the registered read of the sample RAM. The next request is
// taken at the earliest in the cycle in which the last result of the burst is accepted.
// Reset clears write and read indices, play state and frame position, restores register defaults, keeps RAM.
module audio_jitter_ring_buffer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,   // push_sample, burst_length, zero fill
    input  logic                           s_axis_tuser,   // opcode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // out_sample
    output logic                           m_axis_tuser,   // is_silence
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [ajrb_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [ajrb_pkg::CFG_W-1:0]     i_cfg_data
);
    import ajrb_pkg::*;

    t_cmd    cmd;
    t_status status;

    ajrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_opcode   (s_axis_tuser),
        .i_burst_len(s_axis_tdata[22:16]),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    ajrb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_sample   (s_axis_tdata[15:0]),
        .i_burst_len(s_axis_tdata[22:16]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sample   (m_axis_tdata),
        .o_silent   (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

endmodule
